### rtl/lmwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmwc_pkg
// Shared types, constants and helpers of the lag multiply-with-carry generator.
// ----------------------------------------------------------------------------
package lmwc_pkg;

  // ring geometry
  localparam int RING_DEPTH = 256;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [8:0] RING_LIMIT = 9'(RING_DEPTH);

  // field widths
  localparam int BYTE_W   = 8;
  localparam int CARRY_W  = 16;
  localparam int MULT_W   = 16;
  localparam int LAG_W    = 8;
  localparam int VAR_W    = 2;
  localparam int WB_W     = 2;
  localparam int RESULT_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // operation codes
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_GEN  = 1'b1;

  // generate sizes
  localparam logic [WB_W-1:0] WB_ONE = 2'd0;
  localparam logic [WB_W-1:0] WB_TWO = 2'd1;

  // high-part term selection
  localparam logic [VAR_W-1:0] VAR_NONE  = 2'd0;
  localparam logic [VAR_W-1:0] VAR_ADD_X = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MULT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CARRY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR   = 2'd3;

  // configuration reset values
  localparam logic [MULT_W-1:0]  MULT_RST  = 16'd0;
  localparam logic [LAG_W-1:0]   LAG_RST   = 8'd1;
  localparam logic [CARRY_W-1:0] CARRY_RST = 16'd0;
  localparam logic [VAR_W-1:0]   VAR_RST   = 2'd2;

  typedef struct packed {
    logic [MULT_W-1:0]  multiplier;
    logic [LAG_W-1:0]   lag;
    logic [CARRY_W-1:0] initial_carry;
    logic [VAR_W-1:0]   variant;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  rnd_byte;
    logic [CARRY_W-1:0] carry;
    logic [LAG_W-1:0]   next_pos;
  } step_t;

  // Map an 8-bit position to a ring address; out-of-range positions use entry 0.
  function automatic logic [RING_AW-1:0] ring_index(input logic [LAG_W-1:0] pos);
    logic [RING_AW-1:0] idx;
    idx = '0;
    if ({1'b0, pos} < RING_LIMIT) begin
      idx = pos[RING_AW-1:0];
    end
    return idx;
  endfunction

endpackage

### rtl/lmwc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmwc_in_if
// Request channel: seed loads and generate requests.
// ----------------------------------------------------------------------------
interface lmwc_in_if import lmwc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [7:0]        seed_index;
  logic [7:0]        seed_value;
  logic [WB_W-1:0]   word_bytes;

  modport source (output valid, output op, output seed_index, output seed_value,
                  output word_bytes, input ready);
  modport sink   (input valid, input op, input seed_index, input seed_value,
                  input word_bytes, output ready);
endinterface

### rtl/lmwc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmwc_out_if
// Result channel: packed random words.
// ----------------------------------------------------------------------------
interface lmwc_out_if import lmwc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

### rtl/lmwc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmwc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lmwc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmwc_step
// One multiply-with-carry step: new byte, new carry and next ring position.
// ----------------------------------------------------------------------------
module lmwc_step import lmwc_pkg::*; (
  input  logic [BYTE_W-1:0]  x_i,
  input  logic [CARRY_W-1:0] carry_i,
  input  logic [LAG_W-1:0]   pos_i,
  input  cfg_t               cfg_i,
  output step_t              res_o
);

  logic [BYTE_W-1:0]  mul_lo;
  logic [BYTE_W-1:0]  mul_hi;
  logic [CARRY_W-1:0] prod_lo;
  logic [CARRY_W-1:0] prod_hi;
  logic [CARRY_W-1:0] t_val;
  logic [CARRY_W-1:0] hi_term;
  logic [LAG_W:0]     pos_inc;

  assign mul_lo = cfg_i.multiplier[BYTE_W-1:0];
  assign mul_hi = cfg_i.multiplier[MULT_W-1:BYTE_W];

  // two independent 8x8 products
  assign prod_lo = x_i * mul_lo;
  assign prod_hi = x_i * mul_hi;

  // t wraps at 16 bits
  assign t_val = prod_lo + carry_i;

  // select the high-part term
  always_comb begin
    case (cfg_i.variant)
      VAR_NONE:  hi_term = '0;
      VAR_ADD_X: hi_term = {{(CARRY_W-BYTE_W){1'b0}}, x_i};
      default:   hi_term = prod_hi;
    endcase
  end

  // advance the position and wrap at lag
  assign pos_inc = {1'b0, pos_i} + 9'd1;

  always_comb begin
    res_o.rnd_byte = t_val[BYTE_W-1:0];
    res_o.carry    = {{(CARRY_W-BYTE_W){1'b0}}, t_val[CARRY_W-1:BYTE_W]} + hi_term;
    if (pos_inc >= {1'b0, cfg_i.lag}) begin
      res_o.next_pos = '0;
    end else begin
      res_o.next_pos = pos_inc[LAG_W-1:0];
    end
  end

endmodule

### rtl/lag_multiply_with_carry_rng.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lag_multiply_with_carry_rng
// Lag-r multiply-with-carry random byte generator, base 256.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries request words: op 0 loads seed_value into ring entry
//   seed_index and restarts the position and carry; op 1 asks for 1, 2 or 4
//   random bytes (word_bytes), returned as one word on out_o, first byte
//   in bits 7..0 and unused upper bits zero. A seed load returns nothing.
//   Registers (multiplier, lag, initial_carry, variant) are written through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i while no request is in flight.
// Sequencing:
//   A seed load is done in its accept cycle and leaves the block idle. A
//   generate issues the ring read in the accept cycle, then does one
//   read-modify-write of the ring RAM per byte, each byte using the carry
//   of the previous one. The result is valid after the last byte; no new
//   request is accepted until the word has left the engine.
// Reset and stalls:
//   Reset clears carry, position and the registers to their defaults; the
//   ring is undefined until seeded. The output register holds a finished
//   word while out_o stalls, and new requests are accepted meanwhile; only
//   a second finished word waits in the engine until the first is taken.
// ----------------------------------------------------------------------------
module lag_multiply_with_carry_rng import lmwc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  lmwc_in_if.sink               in_i,
  lmwc_out_if.source            out_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_HOLD = 3'b100
  } state_e;

  state_e state_q, state_d;

  cfg_t cfg_q;

  logic [CARRY_W-1:0]  carry_q, carry_d;
  logic [LAG_W-1:0]    pos_q, pos_d;
  logic [1:0]          k_q, k_d;
  logic [1:0]          last_q, last_d;
  logic [RESULT_W-1:0] accum_q, accum_d;
  logic                fwd_valid_q, fwd_valid_d;
  logic [BYTE_W-1:0]   fwd_byte_q, fwd_byte_d;
  logic                out_valid_q, out_valid_d;
  logic [RESULT_W-1:0] out_data_q, out_data_d;

  logic                in_fire;
  logic                slot_free;
  logic                seed_ok;
  logic                ram_we;
  logic [RING_AW-1:0]  ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [RING_AW-1:0]  ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;
  logic [BYTE_W-1:0]   x_cur;
  logic [RING_AW-1:0]  cur_idx;
  logic [RING_AW-1:0]  nxt_idx;
  step_t               step_res;

  assign in_i.ready   = (state_q == S_IDLE);
  assign in_fire      = in_i.valid && in_i.ready;
  assign slot_free    = !out_valid_q || out_o.ready;
  assign seed_ok      = ({1'b0, in_i.seed_index} < RING_LIMIT);
  assign out_o.valid  = out_valid_q;
  assign out_o.random_value = out_data_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.multiplier    <= MULT_RST;
      cfg_q.lag           <= LAG_RST;
      cfg_q.initial_carry <= CARRY_RST;
      cfg_q.variant       <= VAR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MULT:  cfg_q.multiplier    <= cfg_wdata_i;
        CFG_LAG:   cfg_q.lag           <= cfg_wdata_i[LAG_W-1:0];
        CFG_CARRY: cfg_q.initial_carry <= cfg_wdata_i;
        CFG_VAR:   cfg_q.variant       <= cfg_wdata_i[VAR_W-1:0];
        default:   ;
      endcase
    end
  end

  // ring memory
  lmwc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // take the forwarded byte when the ring entry was just rewritten
  assign x_cur   = fwd_valid_q ? fwd_byte_q : ram_rdata;
  assign cur_idx = ring_index(pos_q);
  assign nxt_idx = ring_index(step_res.next_pos);

  lmwc_step u_step (
    .x_i     (x_cur),
    .carry_i (carry_q),
    .pos_i   (pos_q),
    .cfg_i   (cfg_q),
    .res_o   (step_res)
  );

  // sequencer and datapath
  always_comb begin
    state_d     = state_q;
    carry_d     = carry_q;
    pos_d       = pos_q;
    k_d         = k_q;
    last_d      = last_q;
    accum_d     = accum_q;
    fwd_valid_d = 1'b0;
    fwd_byte_d  = fwd_byte_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = in_i.seed_index[RING_AW-1:0];
    ram_wdata   = in_i.seed_value;
    ram_re      = 1'b0;
    ram_raddr   = cur_idx;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.op == OP_SEED) begin
            ram_we  = seed_ok;
            pos_d   = '0;
            carry_d = cfg_q.initial_carry;
          end else begin
            ram_re  = 1'b1;
            k_d     = '0;
            accum_d = '0;
            case (in_i.word_bytes)
              WB_ONE:  last_d = 2'd0;
              WB_TWO:  last_d = 2'd1;
              default: last_d = 2'd3;
            endcase
            state_d = S_CALC;
          end
        end
      end
      S_CALC: begin
        // write the new byte back and advance
        ram_we    = 1'b1;
        ram_waddr = cur_idx;
        ram_wdata = step_res.rnd_byte;
        carry_d   = step_res.carry;
        pos_d     = step_res.next_pos;
        accum_d[{k_q, 3'b000} +: BYTE_W] = step_res.rnd_byte;
        if (k_q == last_q) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_data_d  = accum_d;
            state_d     = S_IDLE;
          end else begin
            state_d = S_HOLD;
          end
        end else begin
          k_d         = k_q + 2'd1;
          ram_re      = 1'b1;
          ram_raddr   = nxt_idx;
          fwd_valid_d = (nxt_idx == cur_idx);
          fwd_byte_d  = step_res.rnd_byte;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = accum_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      carry_q     <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      last_q      <= '0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      carry_q     <= carry_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      last_q      <= last_d;
      fwd_valid_q <= fwd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    accum_q    <= accum_d;
    fwd_byte_q <= fwd_byte_d;
    out_data_q <= out_data_d;
  end

`ifndef SYNTHESIS
  a_fwd_only_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_valid_q |-> state_q == S_CALC)
    else $error("forwarded byte outside of a generate run");

  a_hold_needs_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HOLD |-> out_valid_q)
    else $error("result held back while the output slot is empty");

  a_rose_from_engine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_CALC || $past(state_q) == S_HOLD))
    else $error("output word appeared without a finished generate");

  a_byte_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CALC |-> k_q <= last_q)
    else $error("byte counter ran past the requested size");
`endif

endmodule
